@@ rtl/graph_cycle_detector_defines.svh @@
// Assertion macros for the graph cycle detector.
// Included by the top level; no other dependencies.
`ifndef GRAPH_CYCLE_DETECTOR_DEFINES_SVH
`define GRAPH_CYCLE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GCYC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define GCYC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define GCYC_ASSERT_IMP(label, clk, rst, ante, cons)
`define GCYC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/gcyc_pkg.sv @@
// Shared constants for the graph cycle detector: field widths, command,
// status and color codes. No dependencies.
`default_nettype none

package gcyc_pkg;

  localparam int CFG_W    = 9;
  localparam int NODE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COLOR_W  = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SRC = 2'd2;

  // unvisited, on the current path, finished
  localparam logic [COLOR_W-1:0] MARK_FRESH  = 2'd0;
  localparam logic [COLOR_W-1:0] MARK_OPEN   = 2'd1;
  localparam logic [COLOR_W-1:0] MARK_CLOSED = 2'd2;

endpackage

`default_nettype wire

@@ rtl/graph_cycle_detector.sv @@
// Graph cycle detector top level: edge-list store and DFS sequencer.
// Uses gcyc_pkg, gcyc_ram and graph_cycle_detector_defines.svh.
`default_nettype none
`include "graph_cycle_detector_defines.svh"

// Directed graph held as one edge list per node (up to MAX_EDGES targets),
// searched for a cycle by iterative depth-first search. A command word is
// taken when start is high and busy is low; every word gives exactly one
// result, shown for a single cycle with done high. The receiver cannot
// stall: sample status and cycle_found whenever done is high. Steps after
// the accepting edge: add edge reads the count, then writes; clear zeroes
// one edge count per cycle; unknown source, zero node count or the
// reserved command is answered from the idle state. Detect whitens the L
// nodes in use, then tries each root, walks the edges (looking up the
// target when it is a node in use) and finishes each node; every step is
// a registered read of a memory followed by a decision, so the edge,
// color, count and stack memory ports set the pace. After reset busy
// stays high while all edge counts are cleared; the node_count register
// can be written meanwhile (cfg_ready is always high).
module graph_cycle_detector import gcyc_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic [NODE_W-1:0]   src_node,
  input  wire logic [NODE_W-1:0]   dst_node,
  output logic                     done,
  output logic      [STATUS_W-1:0] status,
  output logic                     cycle_found,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_EDGES + 1);
  localparam int PW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDEPTH = MAX_NODES * MAX_EDGES;
  localparam int EAW    = $clog2(EDEPTH);
  localparam int DW     = $clog2(MAX_NODES + 1);
  localparam int SW     = NW + 2 * CW;

  typedef enum logic [10:0] {
    S_INIT     = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_CLEAR    = 11'b000_0000_0100,
    S_ADD      = 11'b000_0000_1000,
    S_WHITEN   = 11'b000_0001_0000,
    S_ROOT_RD  = 11'b000_0010_0000,
    S_ROOT_CHK = 11'b000_0100_0000,
    S_STEP     = 11'b000_1000_0000,
    S_POP      = 11'b001_0000_0000,
    S_EDGE     = 11'b010_0000_0000,
    S_TGT      = 11'b100_0000_0000
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] node_count;
  logic [NW-1:0]    sweep;
  logic [NW-1:0]    root;
  logic [DW-1:0]    depth;
  logic [NW-1:0]    top_node;
  logic [CW-1:0]    top_pos;
  logic [CW-1:0]    top_cnt;
  logic [NW-1:0]    tgt;
  logic [NW-1:0]    src_q;
  logic [NODE_W-1:0] dst_q;

  logic [CFG_W-1:0] lim;
  logic [NW-1:0]    lim_last;
  logic             root_last;
  logic             top_done;

  // memory ports
  logic             cnt_we;
  logic [NW-1:0]    cnt_addr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_rdata;
  logic             color_we;
  logic [NW-1:0]    color_addr;
  logic [COLOR_W-1:0] color_wdata;
  logic [COLOR_W-1:0] color_rdata;
  logic             edge_we;
  logic [EAW-1:0]   edge_addr;
  logic [NODE_W-1:0] edge_wdata;
  logic [NODE_W-1:0] edge_rdata;
  logic             stk_we;
  logic [NW-1:0]    stk_addr;
  logic [SW-1:0]    stk_wdata;
  logic [SW-1:0]    stk_rdata;

  assign lim       = (int'(node_count) < MAX_NODES) ? node_count : CFG_W'(MAX_NODES);
  assign lim_last  = NW'(lim - CFG_W'(1));
  assign root_last = (root == lim_last);
  assign top_done  = (top_pos >= top_cnt);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  gcyc_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  gcyc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_NODES)) u_color_ram (
    .clk(clk), .we(color_we), .addr(color_addr), .wdata(color_wdata),
    .rdata(color_rdata)
  );

  gcyc_ram #(.WIDTH(NODE_W), .DEPTH(EDEPTH)) u_edge_ram (
    .clk(clk), .we(edge_we), .addr(edge_addr), .wdata(edge_wdata), .rdata(edge_rdata)
  );

  gcyc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
  );

  // Stack ram holds entries 0..depth-2; the top entry lives in top_*.
  always_comb begin
    cnt_we      = 1'b0;
    cnt_addr    = sweep;
    cnt_wdata   = '0;
    color_we    = 1'b0;
    color_addr  = root;
    color_wdata = MARK_FRESH;
    edge_we     = 1'b0;
    edge_addr   = EAW'(top_node) * EAW'(MAX_EDGES) + EAW'(PW'(top_pos));
    edge_wdata  = dst_q;
    stk_we      = 1'b0;
    stk_addr    = NW'(depth - DW'(1));
    stk_wdata   = {top_node, top_pos, top_cnt};
    case (state)
      S_INIT, S_CLEAR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        cnt_addr = NW'(src_node);
      end
      S_ADD: begin
        cnt_addr  = src_q;
        cnt_we    = (cnt_rdata < CW'(MAX_EDGES));
        cnt_wdata = cnt_rdata + CW'(1);
        edge_we   = (cnt_rdata < CW'(MAX_EDGES));
        edge_addr = EAW'(src_q) * EAW'(MAX_EDGES) + EAW'(PW'(cnt_rdata));
      end
      S_WHITEN: begin
        color_addr = sweep;
        color_we   = 1'b1;
      end
      S_ROOT_RD: begin
        cnt_addr = root;
      end
      S_ROOT_CHK: begin
        color_we    = (color_rdata == MARK_FRESH);
        color_wdata = MARK_OPEN;
      end
      S_STEP: begin
        color_addr  = top_node;
        color_we    = top_done;
        color_wdata = MARK_CLOSED;
        stk_addr    = NW'(depth - DW'(2));
      end
      S_EDGE: begin
        color_addr = NW'(edge_rdata);
        cnt_addr   = NW'(edge_rdata);
      end
      S_TGT: begin
        color_addr  = tgt;
        color_we    = (color_rdata == MARK_FRESH);
        color_wdata = MARK_OPEN;
        stk_we      = (color_rdata == MARK_FRESH);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      depth       <= '0;
      node_count  <= '0;
      done        <= 1'b0;
      status      <= ST_DONE;
      cycle_found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      case (state)
        S_INIT: begin
          if (sweep == NW'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + NW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            src_q <= NW'(src_node);
            dst_q <= dst_node;
            case (command)
              CMD_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              CMD_ADD: begin
                if ({1'b0, src_node} >= lim) begin
                  done        <= 1'b1;
                  status      <= ST_NO_SRC;
                  cycle_found <= 1'b0;
                end else begin
                  state <= S_ADD;
                end
              end
              CMD_DETECT: begin
                if (lim == '0) begin
                  done        <= 1'b1;
                  status      <= ST_DONE;
                  cycle_found <= 1'b0;
                end else begin
                  sweep <= '0;
                  state <= S_WHITEN;
                end
              end
              default: begin
                done        <= 1'b1;
                status      <= ST_DONE;
                cycle_found <= 1'b0;
              end
            endcase
          end
        end
        S_ADD: begin
          done        <= 1'b1;
          status      <= (cnt_rdata < CW'(MAX_EDGES)) ? ST_DONE : ST_FULL;
          cycle_found <= 1'b0;
          state       <= S_IDLE;
        end
        S_CLEAR: begin
          if (sweep == NW'(MAX_NODES - 1)) begin
            done        <= 1'b1;
            status      <= ST_DONE;
            cycle_found <= 1'b0;
            state       <= S_IDLE;
          end else begin
            sweep <= sweep + NW'(1);
          end
        end
        S_WHITEN: begin
          if (sweep == lim_last) begin
            root  <= '0;
            state <= S_ROOT_RD;
          end else begin
            sweep <= sweep + NW'(1);
          end
        end
        S_ROOT_RD: begin
          state <= S_ROOT_CHK;
        end
        S_ROOT_CHK: begin
          if (color_rdata == MARK_FRESH) begin
            top_node <= root;
            top_pos  <= '0;
            top_cnt  <= cnt_rdata;
            depth    <= DW'(1);
            state    <= S_STEP;
          end else if (root_last) begin
            done        <= 1'b1;
            status      <= ST_DONE;
            cycle_found <= 1'b0;
            state       <= S_IDLE;
          end else begin
            root  <= root + NW'(1);
            state <= S_ROOT_RD;
          end
        end
        S_STEP: begin
          if (top_done) begin
            depth <= depth - DW'(1);
            if (depth != DW'(1)) begin
              state <= S_POP;
            end else if (root_last) begin
              done        <= 1'b1;
              status      <= ST_DONE;
              cycle_found <= 1'b0;
              state       <= S_IDLE;
            end else begin
              root  <= root + NW'(1);
              state <= S_ROOT_RD;
            end
          end else begin
            top_pos <= top_pos + CW'(1);
            state   <= S_EDGE;
          end
        end
        S_POP: begin
          {top_node, top_pos, top_cnt} <= stk_rdata;
          state <= S_STEP;
        end
        S_EDGE: begin
          // targets outside the nodes in use stay stored but are skipped
          if ({1'b0, edge_rdata} >= lim) begin
            state <= S_STEP;
          end else begin
            tgt   <= NW'(edge_rdata);
            state <= S_TGT;
          end
        end
        S_TGT: begin
          if (color_rdata == MARK_OPEN) begin
            done        <= 1'b1;
            status      <= ST_DONE;
            cycle_found <= 1'b1;
            state       <= S_IDLE;
          end else if (color_rdata == MARK_FRESH) begin
            top_node <= tgt;
            top_pos  <= '0;
            top_cnt  <= cnt_rdata;
            depth    <= depth + DW'(1);
            state    <= S_STEP;
          end else begin
            state <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // every command that leaves the busy states delivers its word
  `GCYC_ASSERT_NXT(a_busy_ends_in_word, clk, rst, busy && (state != S_INIT), busy || done)
  `GCYC_ASSERT_IMP(a_step_has_top, clk, rst, state == S_STEP, depth != '0)
  `GCYC_ASSERT_IMP(a_depth_bound, clk, rst, 1'b1, int'(depth) <= MAX_NODES)

endmodule

`default_nettype wire

@@ rtl/gcyc_ram.sv @@
// Generic single-port RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module gcyc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
